// ----- hdl/smm_pkg.sv -----
// Shared constants, codes and types of the sorted merge membership block.
`timescale 1ns / 1ps

package smm_pkg;

  // Capacity of the set store and derived widths
  localparam int SET_DEPTH = 1024;
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int ADDR_W    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int KEY_W     = 64;

  // Request command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_PROBE  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Operation handed from front to back
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_PROBE  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key;
    logic             end_of_batch;
  } in_item_t;

  typedef struct packed {
    logic found;
    logic last;
  } out_item_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic             eob;
  } q_item_t;

  // Head of the front queue as seen by the back end
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  // Back end state exposed for checking
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] pos;
  } back_stat_t;

endpackage

// ----- hdl/sorted_merge_membership.sv -----
// Sorted merge membership: ascending set store probed by ascending keys.
// Usage:
//   Requests enter through push/full as a queue: a request is taken at a
//   clock edge with push high and full low. command 0 clears the set,
//   1 appends key to the set (ignored once the store holds SET_DEPTH keys),
//   2 probes key; code 3 is taken and dropped. Only probes give a result.
//   Results leave through empty/pop: while empty is low, result holds the
//   oldest result; it is taken at an edge with pop high.
//   A two-entry queue sits between the decode front and the walk engine,
//   so requests keep flowing while a result waits in the output register.
// Processing:
//   Requests run one at a time. Clear and append finish in the idle state. A
//   probe with the pointer at the end of the set finishes at once as a miss;
//   else it reads the entry at the pointer, then compares it with the key and
//   reads the next entry after each smaller entry, as the merge walk goes on.
// Reset and stalls:
//   rst (synchronous) empties the set, rewinds the scan pointer and drops
//   queued requests and any pending result. No clearing pass is needed.
//   While pop stays low the result register holds one result, the next
//   finished probe parks in the engine, the queue fills and full rises.
`timescale 1ns / 1ps

module sorted_merge_membership import smm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  request,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  q_head_t    head;
  logic       deq;
  back_stat_t stat;

  // Decode and queue
  smm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .head    (head),
    .deq     (deq)
  );

  // Store and merge walk
  smm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .deq    (deq),
    .empty  (empty),
    .pop    (pop),
    .result (result),
    .stat   (stat)
  );

`ifndef SYNTHESIS
  // Scan pointer never passes the fill count
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    stat.pos <= stat.count)
    else $error("scan pointer beyond set count");

  // Fill count stays within capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_W'(SET_DEPTH))
    else $error("set count beyond capacity");

  // Reset leaves no result pending and room for requests
  a_reset_clean: assert property (@(posedge clk)
    rst |=> (empty && !full && stat.count == '0))
    else $error("state not clean after reset");

  // The engine only dequeues an operation that is there
  a_deq_valid: assert property (@(posedge clk) disable iff (rst)
    deq |-> head.valid)
    else $error("dequeue from empty queue");
`endif

endmodule

// ----- hdl/smm_front.sv -----
// Front end: accepts requests, decodes the command and queues the operation.
`timescale 1ns / 1ps

module smm_front import smm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t request,
  output q_head_t  head,
  input  logic     deq
);

  localparam int QDEPTH = 2;

  q_item_t    entries [QDEPTH];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] cnt;
  logic       accept;
  logic       enq;
  logic       do_deq;
  q_item_t    item_in;

  // Decode the command; unused codes are accepted and dropped
  always_comb begin
    item_in.key = request.key;
    item_in.eob = request.end_of_batch;
    enq         = 1'b1;
    unique case (request.command)
      CMD_CLEAR:  item_in.op = OP_CLEAR;
      CMD_APPEND: item_in.op = OP_APPEND;
      CMD_PROBE:  item_in.op = OP_PROBE;
      default: begin
        item_in.op = OP_PROBE;
        enq        = 1'b0;
      end
    endcase
  end

  assign full   = (cnt == 2'(QDEPTH));
  assign accept = push && !full && enq;
  assign do_deq = deq && (cnt != 2'd0);

  // Queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      entries[wr_ptr] <= item_in;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (accept) wr_ptr <= ~wr_ptr;
      if (do_deq) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(accept) - 2'(do_deq);
    end
  end

  assign head.valid = (cnt != 2'd0);
  assign head.item  = entries[rd_ptr];

endmodule

// ----- hdl/smm_back.sv -----
// Back end: set store, merge walk and result register.
`timescale 1ns / 1ps

module smm_back import smm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  q_head_t    head,
  output logic       deq,
  output logic       empty,
  input  logic       pop,
  output out_item_t  result,
  output back_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [KEY_W-1:0]  mem [SET_DEPTH];
  logic [KEY_W-1:0]  rd_data;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  pos, pos_next;
  logic [CNT_W-1:0]  pos_inc;
  logic              hit, hit_next;
  logic              out_valid;
  logic              emit_ok;
  logic              emit;
  logic              fin;
  logic              fin_hit;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;

  // Set store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[ADDR_W-1:0]] <= head.item.key;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign pos_inc = pos + CNT_W'(1);
  assign emit_ok = !out_valid || pop;

  // Merge walk control
  always_comb begin
    state_next = state;
    count_next = count;
    pos_next   = pos;
    hit_next   = hit;
    deq        = 1'b0;
    emit       = 1'b0;
    fin        = 1'b0;
    fin_hit    = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = pos[ADDR_W-1:0];
    wr_en      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (head.valid) begin
          unique case (head.item.op)
            OP_CLEAR: begin
              count_next = '0;
              pos_next   = '0;
              deq        = 1'b1;
            end
            OP_APPEND: begin
              if (count < CNT_W'(SET_DEPTH)) begin
                wr_en      = 1'b1;
                count_next = count + CNT_W'(1);
              end
              deq = 1'b1;
            end
            OP_PROBE: begin
              if (pos < count) begin
                rd_en      = 1'b1;
                state_next = ST_CMP;
              end else begin
                fin = 1'b1;
              end
            end
            default: deq = 1'b1;
          endcase
        end
      end
      ST_CMP: begin
        if (rd_data > head.item.key) begin
          fin = 1'b1;
        end else if (rd_data == head.item.key) begin
          fin     = 1'b1;
          fin_hit = 1'b1;
        end else begin
          pos_next = pos_inc;
          if (pos_inc < count) begin
            rd_en   = 1'b1;
            rd_addr = pos_inc[ADDR_W-1:0];
          end else begin
            fin = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        fin     = 1'b1;
        fin_hit = hit;
      end
      default: state_next = ST_IDLE;
    endcase

    // Deliver a finished probe, or park it until the result slot frees
    if (fin) begin
      if (emit_ok) begin
        emit       = 1'b1;
        deq        = 1'b1;
        state_next = ST_IDLE;
        if (head.item.eob) pos_next = '0;
      end else begin
        hit_next   = fin_hit;
        state_next = ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pos   <= pos_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload and parked hit
  always_ff @(posedge clk) begin
    hit <= hit_next;
    if (emit) begin
      result.found <= fin_hit;
      result.last  <= head.item.eob;
    end
  end

  assign empty      = !out_valid;
  assign stat.count = count;
  assign stat.pos   = pos;

endmodule
